// File: sv/mhpq_pkg.sv
// Shared types and constants for the min-heap priority queue.
// Used by mhpq_ctrl, mhpq_dpath and min_heap_priority_queue; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_W        = 32;
    localparam int COUNT_W      = 7;
    localparam int S_DATA_W     = 32;
    localparam int S_USER_W     = 1;
    localparam int M_DATA_W     = 40;
    localparam int M_USER_W     = 2;

    typedef enum logic [0:0] {
        REQ_INSERT = 1'b0,
        REQ_REMOVE = 1'b1
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_LOAD,
        ST_DN_RD,
        ST_DN_CMP,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic ins_start;
        logic rem_start;
        logic up_probe;
        logic up_step;
        logic dn_load;
        logic dn_probe;
        logic dn_step;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic up_root;
        logic up_swap;
        logic dn_leaf;
        logic dn_swap;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

// File: sv/mhpq_ctrl.sv
// Request sequencer for the min-heap priority queue: walks sift-up and sift-down.
// Depends on mhpq_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module mhpq_ctrl (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    input  wire logic [mhpq_pkg::S_USER_W-1:0]     s_tuser,
    output logic                                   s_tready,
    input  wire mhpq_pkg::stat_t                   stat,
    output mhpq_pkg::cmd_t                         cmd
);

    mhpq_pkg::state_t state_reg, state_next;
    logic             is_insert;

    assign is_insert = (s_tuser[0] == mhpq_pkg::REQ_INSERT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mhpq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mhpq_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (is_insert) begin
                        state_next = stat.full ? mhpq_pkg::ST_DONE : mhpq_pkg::ST_UP_RD;
                    end else begin
                        state_next = stat.empty ? mhpq_pkg::ST_DONE : mhpq_pkg::ST_DN_LOAD;
                    end
                end
            end
            mhpq_pkg::ST_UP_RD: begin
                state_next = stat.up_root ? mhpq_pkg::ST_DONE : mhpq_pkg::ST_UP_CMP;
            end
            mhpq_pkg::ST_UP_CMP: begin
                state_next = stat.up_swap ? mhpq_pkg::ST_UP_RD : mhpq_pkg::ST_DONE;
            end
            mhpq_pkg::ST_DN_LOAD: begin
                // count already dropped; an empty heap has nothing to move
                state_next = stat.empty ? mhpq_pkg::ST_DONE : mhpq_pkg::ST_DN_RD;
            end
            mhpq_pkg::ST_DN_RD: begin
                state_next = stat.dn_leaf ? mhpq_pkg::ST_DONE : mhpq_pkg::ST_DN_CMP;
            end
            mhpq_pkg::ST_DN_CMP: begin
                state_next = stat.dn_swap ? mhpq_pkg::ST_DN_RD : mhpq_pkg::ST_DONE;
            end
            mhpq_pkg::ST_DONE: begin
                if (stat.out_free) begin
                    state_next = mhpq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mhpq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            mhpq_pkg::ST_IDLE: begin
                // hold off requests while in reset
                s_tready      = aresetn;
                cmd.ins_start = aresetn && s_tvalid && is_insert;
                cmd.rem_start = aresetn && s_tvalid && !is_insert;
            end
            mhpq_pkg::ST_UP_RD:   cmd.up_probe = 1'b1;
            mhpq_pkg::ST_UP_CMP:  cmd.up_step  = 1'b1;
            mhpq_pkg::ST_DN_LOAD: cmd.dn_load  = 1'b1;
            mhpq_pkg::ST_DN_RD:   cmd.dn_probe = 1'b1;
            mhpq_pkg::ST_DN_CMP:  cmd.dn_step  = 1'b1;
            mhpq_pkg::ST_DONE:    cmd.load_out = stat.out_free;
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/mhpq_dpath.sv
// Heap datapath: key memory, fill count, moving key, compares and result register.
// Depends on mhpq_pkg; driven by commands from mhpq_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module mhpq_dpath #(
    parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire mhpq_pkg::cmd_t                    cmd,
    output mhpq_pkg::stat_t                        stat,
    input  wire logic [mhpq_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [mhpq_pkg::M_DATA_W-1:0]          m_tdata,
    output logic [mhpq_pkg::M_USER_W-1:0]          m_tuser
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 2;
    localparam int KW = mhpq_pkg::KEY_W;

    logic [KW-1:0] heap_mem [0:CAPACITY-1];

    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [KW-1:0] key_reg, key_next;
    logic [KW-1:0] root_reg;
    logic          status_reg, status_next;
    logic [KW-1:0] rd_a_reg, rd_b_reg;

    logic          out_valid_reg;
    logic          out_status_reg;
    logic [KW-1:0] out_min_reg;
    logic          out_mvalid_reg;
    logic [mhpq_pkg::COUNT_W-1:0] out_count_reg;

    logic [AW-1:0] parent_idx;
    logic [XW-1:0] left_w, right_w, count_w;
    logic          left_ok, right_ok;
    logic          pick_left, pick_right;
    logic [KW-1:0] left_best_val;
    logic [AW-1:0] best_idx;
    logic [KW-1:0] best_val;

    logic          we;
    logic [AW-1:0] waddr;
    logic [KW-1:0] wdata;
    logic [AW-1:0] raddr_a, raddr_b;

    // index arithmetic
    assign parent_idx = AW'((pos_reg - 1'b1) >> 1);
    assign left_w     = {1'b0, pos_reg, 1'b1};
    assign right_w    = {1'b0, pos_reg, 1'b0} + XW'(2);
    assign count_w    = XW'(count_reg);
    assign left_ok    = (left_w < count_w);
    assign right_ok   = (right_w < count_w);

    // pick the smaller child; ties go left
    assign pick_left     = left_ok && ($signed(rd_a_reg) < $signed(key_reg));
    assign left_best_val = pick_left ? rd_a_reg : key_reg;
    assign pick_right    = right_ok && ($signed(rd_b_reg) < $signed(left_best_val));

    always_comb begin
        if (pick_right) begin
            best_idx = AW'(right_w);
            best_val = rd_b_reg;
        end else if (pick_left) begin
            best_idx = AW'(left_w);
            best_val = rd_a_reg;
        end else begin
            best_idx = pos_reg;
            best_val = key_reg;
        end
    end

    always_comb begin
        stat.full     = (count_reg == CW'(CAPACITY));
        stat.empty    = (count_reg == '0);
        stat.up_root  = (pos_reg == '0);
        stat.up_swap  = ($signed(key_reg) < $signed(rd_a_reg));
        stat.dn_leaf  = !left_ok;
        stat.dn_swap  = pick_left || pick_right;
        stat.out_free = !out_valid_reg || m_tready;
    end

    // memory port selection
    always_comb begin
        raddr_a = left_w[AW-1:0];
        if (cmd.rem_start) begin
            raddr_a = AW'(count_reg - 1'b1);
        end else if (cmd.up_probe) begin
            raddr_a = parent_idx;
        end
        raddr_b = right_w[AW-1:0];

        we    = 1'b0;
        waddr = pos_reg;
        wdata = key_reg;
        if (cmd.up_probe && stat.up_root) begin
            we = 1'b1;
        end else if (cmd.up_step) begin
            we    = 1'b1;
            wdata = stat.up_swap ? rd_a_reg : key_reg;
        end else if (cmd.dn_probe && stat.dn_leaf) begin
            we = 1'b1;
        end else if (cmd.dn_step) begin
            we    = 1'b1;
            wdata = best_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            heap_mem[waddr] <= wdata;
        end
        rd_a_reg <= heap_mem[raddr_a];
        rd_b_reg <= heap_mem[raddr_b];
    end

    // mirror of the root entry
    always_ff @(posedge aclk) begin
        if (we && (waddr == '0)) begin
            root_reg <= wdata;
        end
    end

    always_comb begin
        count_next  = count_reg;
        pos_next    = pos_reg;
        key_next    = key_reg;
        status_next = status_reg;
        if (cmd.ins_start) begin
            status_next = stat.full;
            if (!stat.full) begin
                pos_next   = AW'(count_reg);
                count_next = CW'(count_reg + 1'b1);
                key_next   = s_tdata[KW-1:0];
            end
        end else if (cmd.rem_start) begin
            status_next = stat.empty;
            if (!stat.empty) begin
                pos_next   = '0;
                count_next = CW'(count_reg - 1'b1);
            end
        end else if (cmd.up_step) begin
            if (stat.up_swap) begin
                pos_next = parent_idx;
            end
        end else if (cmd.dn_load) begin
            key_next = rd_a_reg;
        end else if (cmd.dn_step) begin
            pos_next = best_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        key_reg    <= key_next;
        status_reg <= status_next;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_status_reg <= status_reg;
            out_min_reg    <= stat.empty ? '0 : root_reg;
            out_mvalid_reg <= !stat.empty;
            out_count_reg  <= mhpq_pkg::COUNT_W'(count_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_min_reg};
    assign m_tuser  = {out_mvalid_reg, out_status_reg};

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("fill count above capacity");

    a_write_in_heap: assert property (@(posedge aclk) disable iff (!aresetn)
        we |-> (CW'(waddr) < count_reg))
        else $error("heap write outside occupied range");

    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.ins_start && !stat.full) |=> (count_reg == CW'($past(count_reg) + 1'b1)))
        else $error("insert did not advance count");

    a_remove_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.rem_start && !stat.empty) |=> (count_reg == CW'($past(count_reg) - 1'b1)))
        else $error("remove did not drop count");
`endif

endmodule

`default_nettype wire

// File: sv/min_heap_priority_queue.sv
// Min-heap priority queue: one request in, one result out, one request in flight.
// A rejected request (insert when full, remove when empty) goes straight to the result load; the
// next request is taken the cycle after the result loads. Each heap level takes one read state
// and one compare/write state.
// Reset (aresetn low, synchronous) empties the queue and the result slot; memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module min_heap_priority_queue #(
    parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [mhpq_pkg::S_DATA_W-1:0]     s_tdata,   // [31:0] key
    input  wire logic [mhpq_pkg::S_USER_W-1:0]     s_tuser,   // [0] req_type
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [mhpq_pkg::M_DATA_W-1:0]          m_tdata,   // [31:0] min_key, [38:32] count
    output logic [mhpq_pkg::M_USER_W-1:0]          m_tuser    // [0] status, [1] min_valid
);

    mhpq_pkg::cmd_t  cmd;
    mhpq_pkg::stat_t stat;

    mhpq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mhpq_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// File: bench/min_heap_priority_queue_tb.sv
// Self-checking bench for min_heap_priority_queue: random and directed insert/remove requests,
// each result checked against a behavioral heap kept in the bench.
// Depends on mhpq_pkg and the min_heap_priority_queue RTL.
`timescale 1ns / 1ps

module min_heap_priority_queue_tb;

    localparam int HEAP_DEPTH = mhpq_pkg::CAPACITY_DEF;
    localparam logic [mhpq_pkg::KEY_W-1:0] KEY_MIN = 32'h8000_0000;
    localparam logic [mhpq_pkg::KEY_W-1:0] KEY_MAX = 32'h7fff_ffff;

    typedef struct packed {
        logic                              status;
        logic signed [mhpq_pkg::KEY_W-1:0] min_key;
        logic                              min_valid;
        logic [mhpq_pkg::COUNT_W-1:0]      count;
    } heap_result_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [mhpq_pkg::S_DATA_W-1:0]   s_tdata = '0;     // [31:0] key
    logic [mhpq_pkg::S_USER_W-1:0]   s_tuser = '0;     // [0] req_type
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [mhpq_pkg::M_DATA_W-1:0]   m_tdata;          // [31:0] min_key, [38:32] count
    logic [mhpq_pkg::M_USER_W-1:0]   m_tuser;          // [0] status, [1] min_valid

    // bench copy of the heap
    logic signed [mhpq_pkg::KEY_W-1:0] heap_keys [HEAP_DEPTH];
    int                                keys_held = 0;
    heap_result_t                      expected_results[$];
    int                                errors = 0;
    bit                                idle_on = 1'b1;
    int                                stall_left = 0;

    min_heap_priority_queue #(.CAPACITY(HEAP_DEPTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic heap_result_t apply_heap_request(mhpq_pkg::req_t kind,
                                                        logic signed [mhpq_pkg::KEY_W-1:0] key);
        heap_result_t                      res;
        int                                pos;
        int                                parent;
        int                                left;
        int                                right;
        int                                best;
        logic signed [mhpq_pkg::KEY_W-1:0] tmp;
        res.status = 1'b0;
        if (kind == mhpq_pkg::REQ_INSERT) begin
            if (keys_held >= HEAP_DEPTH) begin
                res.status = 1'b1;
            end else begin
                pos = keys_held;
                heap_keys[pos] = key;
                keys_held++;
                // bubble up while the parent is strictly greater
                while (pos > 0) begin
                    parent = (pos - 1) / 2;
                    if (heap_keys[pos] >= heap_keys[parent])
                        break;
                    tmp = heap_keys[pos];
                    heap_keys[pos] = heap_keys[parent];
                    heap_keys[parent] = tmp;
                    pos = parent;
                end
            end
        end else begin
            if (keys_held == 0) begin
                res.status = 1'b1;
            end else begin
                keys_held--;
                heap_keys[0] = heap_keys[keys_held];
                pos = 0;
                // push down toward the smaller child; the left child wins a tie
                while (pos < keys_held) begin
                    left = 2 * pos + 1;
                    right = left + 1;
                    best = pos;
                    if (left < keys_held && heap_keys[left] < heap_keys[best])
                        best = left;
                    if (right < keys_held && heap_keys[right] < heap_keys[best])
                        best = right;
                    if (best == pos)
                        break;
                    tmp = heap_keys[pos];
                    heap_keys[pos] = heap_keys[best];
                    heap_keys[best] = tmp;
                    pos = best;
                end
            end
        end
        res.min_valid = (keys_held > 0);
        res.min_key = (keys_held > 0) ? heap_keys[0] : '0;
        res.count = keys_held[mhpq_pkg::COUNT_W-1:0];
        return res;
    endfunction

    function automatic logic [mhpq_pkg::KEY_W-1:0] pick_key();
        case ($urandom_range(0, 7)) inside
            0:       return KEY_MIN + $urandom_range(0, 3);
            1:       return KEY_MAX - $urandom_range(0, 3);
            [2:3]:   return $urandom_range(0, 15) - 8;   // dense range to force duplicates
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    task automatic send_request(mhpq_pkg::req_t kind, logic [mhpq_pkg::KEY_W-1:0] key);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= key;
        s_tuser <= kind;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_results.push_back(apply_heap_request(kind, key));
    endtask

    // receiver side: stall in random bursts while idling is enabled
    always @(posedge aclk) begin
        if (idle_on && stall_left == 0 && $urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 8);
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        heap_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unrequested result, status", m_tuser[0], 0);
            end else begin
                want = expected_results.pop_front();
                if (m_tuser[0] !== want.status)
                    report_mismatch("status", m_tuser[0], want.status);
                if (m_tdata[31:0] !== want.min_key)
                    report_mismatch("min_key", $signed(m_tdata[31:0]), want.min_key);
                if (m_tuser[1] !== want.min_valid)
                    report_mismatch("min_valid", m_tuser[1], want.min_valid);
                if (m_tdata[38:32] !== want.count)
                    report_mismatch("count", m_tdata[38:32], want.count);
            end
        end
    end

    task automatic test_empty_queue();
        send_request(mhpq_pkg::REQ_REMOVE, '1);
        send_request(mhpq_pkg::REQ_REMOVE, '0);
    endtask

    task automatic test_extreme_keys();
        send_request(mhpq_pkg::REQ_INSERT, 32'd0);
        send_request(mhpq_pkg::REQ_INSERT, KEY_MAX);
        send_request(mhpq_pkg::REQ_INSERT, KEY_MIN);
        send_request(mhpq_pkg::REQ_INSERT, '1);
        send_request(mhpq_pkg::REQ_INSERT, 32'd1);
        send_request(mhpq_pkg::REQ_INSERT, KEY_MAX);
        send_request(mhpq_pkg::REQ_INSERT, KEY_MIN);
        send_request(mhpq_pkg::REQ_INSERT, '1);
        // drain past empty
        repeat (9) send_request(mhpq_pkg::REQ_REMOVE, $urandom);
    endtask

    task automatic test_fill_and_overflow();
        repeat (HEAP_DEPTH + 3) send_request(mhpq_pkg::REQ_INSERT, pick_key());
        repeat (HEAP_DEPTH + 2) send_request(mhpq_pkg::REQ_REMOVE, $urandom);
    endtask

    task automatic test_random_mix(int rounds);
        repeat (rounds) begin
            // lean toward inserts, then toward removes, so the queue swings full to empty
            repeat (125) begin
                if ($urandom_range(0, 3) != 0)
                    send_request(mhpq_pkg::REQ_INSERT, pick_key());
                else
                    send_request(mhpq_pkg::REQ_REMOVE, $urandom);
            end
            repeat (125) begin
                if ($urandom_range(0, 3) == 0)
                    send_request(mhpq_pkg::REQ_INSERT, pick_key());
                else
                    send_request(mhpq_pkg::REQ_REMOVE, $urandom);
            end
        end
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        repeat (120) begin
            if ($urandom_range(0, 1) == 0)
                send_request(mhpq_pkg::REQ_INSERT, pick_key());
            else
                send_request(mhpq_pkg::REQ_REMOVE, $urandom);
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_queue();
        test_extreme_keys();
        test_fill_and_overflow();
        test_random_mix(4);
        test_back_to_back();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        // let any stray result show up
        repeat (40) @(posedge aclk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
